// ----- hdl/iqm_pkg.sv -----
`timescale 1ns / 1ps

package iqm_pkg;

   // Fixed geometry of the packed words
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 32;
   localparam int WORD_LANES = WORD_W / BYTE_W;

   // Saturation bounds of an int8 result
   localparam logic signed [WORD_W-1:0] SAT_MAX = 32'sd127;
   localparam logic signed [WORD_W-1:0] SAT_MIN = -32'sd128;

   // Register indexes of the configuration port
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUANT_MULTIPLIER = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUANT_SHIFT      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELU_ENABLE      = 2'd2;

   // Input word
   typedef struct packed {
      logic [WORD_W-1:0] weight_word;
      logic [WORD_W-1:0] activation_word;
      logic              last;
   } iqm_req_type;

   // Result word
   typedef struct packed {
      logic [WORD_W-1:0] packed_result;
   } iqm_rsp_type;

   // Requantization settings
   typedef struct packed {
      logic [WORD_W-1:0] quant_multiplier;
      logic [4:0]        quant_shift;
      logic              relu_enable;
   } iqm_cfg_type;

   // Per-cycle lane strobes
   typedef struct packed {
      logic accumulate;   // add this word's product
      logic requant;      // take acc * multiplier, clear acc
      logic settle;       // shift, clamp and store the byte
   } iqm_lane_ctl_type;

endpackage

// ----- hdl/iqm_stream_if.sv -----
`timescale 1ns / 1ps

interface iqm_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/int8_quad_mac_requantize.sv -----
`timescale 1ns / 1ps

// Packed int8 dot product with per-lane requantization. Every req word carries
// WORD_LANES signed int8 weights and activations; each lane multiplies its pair
// and adds into its own wrapping 32-bit accumulator, one word per cycle while
// req_ready is high. A word marked last is accumulated, then the lanes
// requantize (low-word multiply by quant_multiplier into a product register,
// then arithmetic shift, optional ReLU and int8 clamp into a byte register) and
// the merge stage packs the bytes into the rsp output register; the
// accumulators are clear by then. req_ready is low from the last word until the
// bytes are loaded into that register. Non-last words keep streaming while a
// result waits in the output register; the bytes of the next last word hold in
// the lanes, with req_ready low, until that register is taken. Write csr_* only
// when idle.
module int8_quad_mac_requantize
   import iqm_pkg::*;
#(
   parameter int LANES = 4
)
(
   input  logic                   clock,
   input  logic                   reset,
   iqm_stream_if.sink             req_if,
   iqm_stream_if.source           rsp_if,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_write_data
);

   iqm_cfg_type      cfg_ff;
   iqm_lane_ctl_type lane_ctl;
   logic             requant_ff;
   logic             settle_ff;
   logic             merge_busy;
   logic             req_fire;
   logic [BYTE_W-1:0] lane_bytes [LANES];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quant_multiplier <= 32'd1;
         cfg_ff.quant_shift      <= 5'd8;
         cfg_ff.relu_enable      <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_QUANT_MULTIPLIER: cfg_ff.quant_multiplier <= csr_write_data;
            CSR_QUANT_SHIFT:      cfg_ff.quant_shift      <= csr_write_data[4:0];
            CSR_RELU_ENABLE:      cfg_ff.relu_enable      <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // One result in flight at a time
   assign req_if.ready = !requant_ff && !settle_ff && !merge_busy;
   assign req_fire     = req_if.valid && req_if.ready;

   // Multiply stage, then shift and clamp stage
   always_ff @(posedge clock) begin
      if (reset) begin
         requant_ff <= 1'b0;
         settle_ff  <= 1'b0;
      end else begin
         requant_ff <= req_fire && req_if.payload.last;
         settle_ff  <= requant_ff;
      end
   end

   assign lane_ctl.accumulate = req_fire;
   assign lane_ctl.requant    = requant_ff;
   assign lane_ctl.settle     = settle_ff;

   // Lanes; those above the word see zero operands
   for (genvar n = 0; n < LANES; n++) begin : g_lane
      logic signed [BYTE_W-1:0] w_byte;
      logic signed [BYTE_W-1:0] a_byte;
      if (n < WORD_LANES) begin : g_in_word
         assign w_byte = req_if.payload.weight_word[n*BYTE_W +: BYTE_W];
         assign a_byte = req_if.payload.activation_word[n*BYTE_W +: BYTE_W];
      end else begin : g_beyond
         assign w_byte = '0;
         assign a_byte = '0;
      end
      iqm_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (lane_ctl),
         .cfg        (cfg_ff),
         .weight     (w_byte),
         .activation (a_byte),
         .result     (lane_bytes[n])
      );
   end

   // Pack and hold the result word
   iqm_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .settle     (settle_ff),
      .lane_bytes (lane_bytes),
      .busy       (merge_busy),
      .rsp_if     (rsp_if)
   );

   // Input stalls right after a last word
   a_stall_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_if.payload.last) |=> !req_if.ready)
      else $error("req accepted during requantization");

   // Requant stage always hands over through settle to the merge stage
   a_requant_to_merge: assert property (@(posedge clock) disable iff (reset)
      requant_ff |=> settle_ff ##1 merge_busy)
      else $error("requantized bytes lost");

   // Never two results between lanes and output
   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      !(requant_ff && merge_busy))
      else $error("two results in flight");

endmodule

// ----- hdl/iqm_lane.sv -----
`timescale 1ns / 1ps

module iqm_lane
   import iqm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  iqm_lane_ctl_type         ctl,
   input  iqm_cfg_type              cfg,
   input  logic signed [BYTE_W-1:0] weight,
   input  logic signed [BYTE_W-1:0] activation,
   output logic [BYTE_W-1:0]        result
);

   logic [WORD_W-1:0]          acc_ff, acc_in;
   logic [WORD_W-1:0]          prod_ff, prod_in;
   logic [BYTE_W-1:0]          byte_ff, byte_in;
   logic signed [2*BYTE_W-1:0] mac_product;
   logic signed [WORD_W-1:0]   shifted;
   logic signed [WORD_W-1:0]   clamped;

   // int8 x int8 product, sign-extended into the wrapping accumulator
   assign mac_product = weight * activation;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.requant) begin
         acc_in = '0;
      end else if (ctl.accumulate) begin
         acc_in = acc_ff + {{(WORD_W-2*BYTE_W){mac_product[2*BYTE_W-1]}}, mac_product};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // Requant multiply, low word only
   assign prod_in = acc_ff * cfg.quant_multiplier;

   always_ff @(posedge clock) begin
      if (ctl.requant) begin
         prod_ff <= prod_in;
      end
   end

   // Arithmetic shift, optional ReLU, clamp to int8
   always_comb begin
      shifted = $signed(prod_ff) >>> cfg.quant_shift;
      clamped = shifted;
      if (cfg.relu_enable && shifted < 0) begin
         clamped = '0;
      end
      if (clamped > SAT_MAX) begin
         clamped = SAT_MAX;
      end else if (clamped < SAT_MIN) begin
         clamped = SAT_MIN;
      end
      byte_in = clamped[BYTE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.settle) begin
         byte_ff <= byte_in;
      end
   end

   assign result = byte_ff;

endmodule

// ----- hdl/iqm_merge.sv -----
`timescale 1ns / 1ps

module iqm_merge
   import iqm_pkg::*;
#(
   parameter int LANES = 4
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               settle,
   input  logic [BYTE_W-1:0]  lane_bytes [LANES],
   output logic               busy,
   iqm_stream_if.source       rsp_if
);

   localparam int PACK_LANES = (LANES < WORD_LANES) ? LANES : WORD_LANES;

   logic              pending_ff, pending_in;
   logic              valid_ff, valid_in;
   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] packed_word;
   logic              load;

   // Lanes above the word are dropped, missing lanes read as zero
   always_comb begin
      packed_word = '0;
      for (int n = 0; n < PACK_LANES; n++) begin
         packed_word[n*BYTE_W +: BYTE_W] = lane_bytes[n];
      end
   end

   // Bytes wait in the lanes until the output register frees up
   assign load = pending_ff && (!valid_ff || rsp_if.ready);

   always_comb begin
      pending_in = pending_ff;
      valid_in   = valid_ff;
      if (settle) begin
         pending_in = 1'b1;
      end else if (load) begin
         pending_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= packed_word;
      end
   end

   assign busy                         = pending_ff;
   assign rsp_if.valid                 = valid_ff;
   assign rsp_if.payload.packed_result = data_ff;

endmodule

// ----- dv/int8_quad_mac_requantize_test.sv -----
`timescale 1ns / 1ps

module int8_quad_mac_requantize_test;
   import iqm_pkg::*;

   localparam int LANES        = 4;
   localparam int DRAIN_CYCLES = 8;
   localparam int BLOCK_WORDS  = 58;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;   // no register behind it

   // Predicts the packed results and holds those still owed by the block
   class quad_mac_scoreboard;
      logic [WORD_W-1:0] multiplier;
      logic [4:0]        shift_amount;
      logic              relu_on;
      logic [WORD_W-1:0] lane_acc [LANES];
      iqm_rsp_type       expected_packed [$];
      int                words_seen;
      int                results_checked;
      int                mismatches;

      function new();
         multiplier   = 32'd1;
         shift_amount = 5'd8;
         relu_on      = 1'b0;
         foreach (lane_acc[n]) lane_acc[n] = '0;
      endfunction

      // Mirror of a register write, masked to the register width
      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [WORD_W-1:0] data);
         case (index)
            CSR_QUANT_MULTIPLIER: multiplier   = data;
            CSR_QUANT_SHIFT:      shift_amount = data[4:0];
            CSR_RELU_ENABLE:      relu_on      = data[0];
            default: ;
         endcase
      endfunction

      // Low-word scale, arithmetic shift, optional ReLU, int8 clamp
      function logic [BYTE_W-1:0] requantize_lane(logic [WORD_W-1:0] acc);
         logic [WORD_W-1:0]        scaled;
         logic signed [WORD_W-1:0] shifted;
         scaled  = acc * multiplier;
         shifted = $signed(scaled) >>> shift_amount;
         if (relu_on && shifted < 0) shifted = '0;
         if (shifted > SAT_MAX) shifted = SAT_MAX;
         else if (shifted < SAT_MIN) shifted = SAT_MIN;
         return shifted[BYTE_W-1:0];
      endfunction

      // Accepted input word: accumulate every lane, emit on last
      function void note_word(iqm_req_type w);
         logic signed [BYTE_W-1:0] wb;
         logic signed [BYTE_W-1:0] ab;
         logic signed [15:0]       prod;
         iqm_rsp_type              r;
         r = '0;
         for (int n = 0; n < LANES; n++) begin
            wb = (n < WORD_LANES) ? w.weight_word[BYTE_W*n +: BYTE_W] : '0;
            ab = (n < WORD_LANES) ? w.activation_word[BYTE_W*n +: BYTE_W] : '0;
            prod = wb * ab;
            lane_acc[n] += {{16{prod[15]}}, prod};
         end
         words_seen++;
         if (w.last) begin
            for (int n = 0; n < LANES; n++) begin
               if (n < WORD_LANES) r.packed_result[BYTE_W*n +: BYTE_W] = requantize_lane(lane_acc[n]);
               lane_acc[n] = '0;
            end
            expected_packed.push_back(r);
         end
      endfunction

      // Accepted result word against the oldest prediction
      function void check_result(iqm_rsp_type got);
         iqm_rsp_type want;
         if (expected_packed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result %h with nothing expected", $time, got.packed_result);
            return;
         end
         want = expected_packed.pop_front();
         results_checked++;
         if (got.packed_result !== want.packed_result) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: packed_result mismatch: expected %h, got %h",
                        $time, want.packed_result, got.packed_result);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0]      csr_write_data;

   iqm_stream_if #(.payload_type(iqm_req_type)) req_if ();
   iqm_stream_if #(.payload_type(iqm_rsp_type)) rsp_if ();

   quad_mac_scoreboard board = new();

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int settings_written   = 0;

   int8_quad_mac_requantize #(.LANES(LANES)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Hard stop in case the block hangs
   initial begin
      #15_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Result side: random stalls, check every accepted word
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) board.check_result(rsp_if.payload);
         rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // One word, held until accepted; valid stays high for a following word
   task automatic send_word(logic [WORD_W-1:0] w, logic [WORD_W-1:0] a, logic last);
      iqm_req_type item;
      item.weight_word     = w;
      item.activation_word = a;
      item.last            = last;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      board.note_word(item);
   endtask

   // Stop sending, let every result arrive, then let the lanes settle
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (board.expected_packed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] index, logic [WORD_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      board.write_reg(index, data);
   endtask

   // All three registers plus a write to the unused index; only while idle
   task automatic write_settings(logic [WORD_W-1:0] mult, logic [WORD_W-1:0] shift_data,
                                 logic [WORD_W-1:0] relu_data);
      csr_write(CSR_QUANT_MULTIPLIER, mult);
      csr_write(CSR_QUANT_SHIFT, shift_data);
      csr_write(CSR_RELU_ENABLE, relu_data);
      csr_write(CSR_SPARE_INDEX, $urandom());
      csr_write_enable <= 1'b0;
      settings_written++;
   endtask

   // Lane bytes lean towards the int8 extremes, zero and minus one
   function automatic logic [WORD_W-1:0] pick_word();
      logic [WORD_W-1:0] w;
      for (int n = 0; n < WORD_LANES; n++) begin
         case ($urandom_range(0, 7))
            0:       w[BYTE_W*n +: BYTE_W] = 8'h80;
            1:       w[BYTE_W*n +: BYTE_W] = 8'h7F;
            2:       w[BYTE_W*n +: BYTE_W] = 8'h00;
            3:       w[BYTE_W*n +: BYTE_W] = 8'hFF;
            default: w[BYTE_W*n +: BYTE_W] = 8'($urandom_range(0, 255));
         endcase
      end
      return w;
   endfunction

   // Mostly moderate scaling so lanes land in range, sometimes the extremes
   task automatic random_settings();
      logic [WORD_W-1:0] mult;
      logic [4:0]        shift;
      logic [WORD_W-1:0] junk;
      junk = $urandom();
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 3))
            0:       mult = 32'h7FFF_FFFF;
            1:       mult = 32'h8000_0000;
            2:       mult = 32'hFFFF_FFFF;
            default: mult = 32'h0000_0000;
         endcase
         shift = $urandom_range(0, 1) ? 5'd31 : 5'd0;
      end else begin
         mult  = 32'($urandom_range(1, 65536));
         if ($urandom_range(0, 2) == 0) mult = -mult;
         shift = 5'($urandom_range(8, 24));
      end
      write_settings(mult, {junk[WORD_W-1:5], shift}, $urandom());
   endtask

   // One dot product of random content, ending in a last word
   task automatic send_dot_product();
      int len;
      case ($urandom_range(0, 9))
         0, 1:    len = $urandom_range(7, 24);
         2:       len = 1;
         default: len = $urandom_range(1, 6);
      endcase
      for (int k = 1; k <= len; k++) send_word(pick_word(), pick_word(), k == len);
   endtask

   initial begin
      int words_in_block;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_QUANT_MULTIPLIER;
      csr_write_data   <= '0;
      req_if.valid     <= 1'b0;
      req_if.payload   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: scale 1, shift 8, no ReLU
      send_word(32'h7F7F_7F7F, 32'h7F7F_7F7F, 1'b1);
      send_word(32'h8080_8080, 32'h8080_8080, 1'b1);
      send_word(32'h7F7F_7F7F, 32'h8080_8080, 1'b1);
      send_word(32'h01FF_807F, 32'hFF01_807F, 1'b1);
      // several words before the last one
      send_word(32'h7F80_7F80, 32'h7F7F_8080, 1'b0);
      send_word(32'h7F80_7F80, 32'h7F7F_8080, 1'b0);
      send_word(32'h1234_5678, 32'h9ABC_DEF0, 1'b0);
      send_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      wait_drained();

      // No shift: saturation both ways
      write_settings(32'd1, 32'd0, 32'd0);
      send_word(32'h7F7F_7F7F, 32'h7F7F_7F7F, 1'b1);
      send_word(32'h7F7F_7F7F, 32'h8080_8080, 1'b1);
      send_word(32'h0000_0000, 32'h0000_0000, 1'b1);
      wait_drained();

      // Upper bits of the written data are masked off; ReLU on
      write_settings(32'd1, 32'hFFFF_FFE4, 32'hFFFF_FFFF);
      send_word(32'h7F80_01FF, 32'h8080_FF01, 1'b1);
      send_word(32'h0101_0101, 32'hFFFF_0101, 1'b1);
      wait_drained();

      // Extreme factors: the scaled product keeps only its low word
      write_settings(32'h7FFF_FFFF, 32'd31, 32'd0);
      send_word(32'h7F80_7F80, 32'h7F7F_8080, 1'b1);
      send_word(32'h0102_FF80, 32'h0301_7F80, 1'b1);
      wait_drained();
      write_settings(32'h8000_0000, 32'd31, 32'hFFFF_FFFE);
      send_word(32'h7F80_0101, 32'h7F7F_0101, 1'b1);
      send_word(32'h01FF_0000, 32'h0101_0000, 1'b1);
      wait_drained();
      write_settings(32'hFFFF_FFFF, 32'd0, 32'd0);
      send_word(32'h7F80_01FF, 32'h7F80_0101, 1'b1);
      send_word(32'h0000_0180, 32'h0000_0101, 1'b1);
      wait_drained();

      // Random dot products over the idling phases, new settings per block
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1:       begin sender_idle_pct = 82; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 82; end
            default: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
         endcase
         for (int blk = 0; blk < 3; blk++) begin
            wait_drained();
            random_settings();
            words_in_block = board.words_seen;
            while (board.words_seen - words_in_block < BLOCK_WORDS) begin
               send_dot_product();
               if ($urandom_range(0, 19) == 0) wait_drained();
            end
         end
      end

      wait_drained();
      $display("Checked %0d packed results from %0d words, with saturation and extreme factors.",
               board.results_checked, board.words_seen);
      $display("Covered %0d register settings over four sender and receiver idling mixes.",
               settings_written);
      if (board.mismatches == 0 && board.expected_packed.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
